// ----- rtl/core/crc8cfp_pkg.sv -----
// Shared types, constants and functions for the CRC-8 command frame parser.
// No dependencies; compiled first.

package crc8cfp_pkg;

  // Frame layout and limits
  localparam int unsigned MAX_PAYLOAD  = 32;
  localparam logic [7:0]  MAX_LENGTH   = 8'(MAX_PAYLOAD);
  localparam logic [7:0]  TYPE_STOP    = 8'h00;
  localparam logic [7:0]  TYPE_RUN     = 8'h01;
  localparam logic [7:0]  TYPE_DIFF    = 8'h10;
  localparam logic [7:0]  DIFF_LENGTH  = 8'd8;
  localparam logic [7:0]  STORED_BYTES = 8'd8;

  // CRC-8/MAXIM, reflected
  localparam logic [7:0]  CRC_POLY     = 8'h8C;
  localparam logic [7:0]  CRC_INIT     = 8'h00;

  // Register reset values
  localparam logic [15:0] TIMEOUT_RESET = 16'd500;
  localparam logic [7:0]  HEADER_RESET  = 8'hA5;

  localparam logic [16:0] AGE_MAX = 17'h1FFFF;

  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_GOOD   = 3'd1,
    EV_CRC    = 3'd2,
    EV_LENGTH = 3'd3,
    EV_TYPE   = 3'd4
  } frame_event_t;

  typedef enum logic {
    REG_TIMEOUT = 1'b0,
    REG_HEADER  = 1'b1
  } cfg_reg_t;

  // Per-beat report from the parser to the command logic
  typedef struct packed {
    logic        length_error;
    logic        crc_error;
    logic        frame_ok;
    logic [7:0]  frame_type;
    logic [7:0]  frame_length;
    logic [63:0] payload;
  } parse_result_t;

  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic logic is_nan_bits(input logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
  endfunction

endpackage

// ----- rtl/core/crc8cfp_if.sv -----
// Valid/ready channel interfaces for the CRC-8 command frame parser.
// Standalone; widths follow the fixed item and result fields.

interface crc8cfp_item_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] rx_byte;

  modport source (output valid, output kind, output rx_byte, input ready);
  modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

interface crc8cfp_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  frame_event;
  logic        run_mode;
  logic        command_active;
  logic [31:0] linear_command;
  logic [31:0] angular_command;
  logic [31:0] good_count;
  logic [31:0] crc_error_count;
  logic [31:0] length_error_count;
  logic [31:0] type_error_count;

  modport source (
    output valid, output frame_event, output run_mode, output command_active,
    output linear_command, output angular_command, output good_count,
    output crc_error_count, output length_error_count, output type_error_count,
    input ready
  );
  modport sink (
    input valid, input frame_event, input run_mode, input command_active,
    input linear_command, input angular_command, input good_count,
    input crc_error_count, input length_error_count, input type_error_count,
    output ready
  );
endinterface

// ----- rtl/core/crc8_command_frame_parser_unit.sv -----
// Top level of the CRC-8 command frame parser: APB registers, command and
// timeout logic, event counters and the result register.
// Depends on crc8cfp_pkg, crc8cfp_if and crc8cfp_frame_parser.
// Latency: a result is valid the cycle after its item is accepted.
// Throughput: one item per cycle; a held result stalls input only while unread.
// Reset (rst, synchronous): parser waits for a header, stop mode, no command,
// counters zero, timeout 500 ticks, header byte 0xA5.

module crc8_command_frame_parser_unit
  import crc8cfp_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  crc8cfp_item_if.sink            item,
  crc8cfp_result_if.source        result,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [2:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  // Configuration registers
  logic [15:0] timeout_ticks;
  logic [7:0]  header_value;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
      header_value  <= HEADER_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (cfg_reg_t'(paddr[2]))
        REG_TIMEOUT: timeout_ticks <= pwdata[15:0];
        REG_HEADER:  header_value  <= pwdata[7:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_reg_t'(paddr[2]))
      REG_TIMEOUT: prdata = {16'd0, timeout_ticks};
      REG_HEADER:  prdata = {24'd0, header_value};
      default:     prdata = '0;
    endcase
  end

  // Handshake: the result register frees up as soon as it is read
  logic accept;
  assign item.ready = !result.valid || result.ready;
  assign accept     = item.valid && item.ready;

  parse_result_t parse;

  crc8cfp_frame_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (accept && !item.kind),
    .rx_byte      (item.rx_byte),
    .header_value (header_value),
    .result       (parse)
  );

  // Command and counter state
  logic         mode_run, mode_run_next;
  logic         active_flag, active_flag_next;
  logic [31:0]  linear_value, linear_value_next;
  logic [31:0]  angular_value, angular_value_next;
  logic [16:0]  elapsed_ticks, elapsed_ticks_next;
  logic [31:0]  good_total, good_total_next;
  logic [31:0]  crc_error_total, crc_error_total_next;
  logic [31:0]  length_error_total, length_error_total_next;
  logic [31:0]  type_error_total, type_error_total_next;
  frame_event_t event_next;
  logic [31:0]  diff_linear, diff_angular;

  assign diff_linear  = parse.payload[31:0];
  assign diff_angular = parse.payload[63:32];

  always_comb begin
    mode_run_next           = mode_run;
    active_flag_next        = active_flag;
    linear_value_next       = linear_value;
    angular_value_next      = angular_value;
    elapsed_ticks_next      = elapsed_ticks;
    good_total_next         = good_total;
    crc_error_total_next    = crc_error_total;
    length_error_total_next = length_error_total;
    type_error_total_next   = type_error_total;
    event_next              = EV_NONE;

    if (item.kind) begin
      // Tick: age a live command, drop it once past the timeout
      if (active_flag) begin
        if (elapsed_ticks != AGE_MAX) begin
          elapsed_ticks_next = elapsed_ticks + 17'd1;
        end
        if (elapsed_ticks_next > {1'b0, timeout_ticks}) begin
          active_flag_next   = 1'b0;
          linear_value_next  = '0;
          angular_value_next = '0;
        end
      end
    end else if (parse.length_error) begin
      length_error_total_next = length_error_total + 32'd1;
      event_next              = EV_LENGTH;
    end else if (parse.crc_error) begin
      crc_error_total_next = crc_error_total + 32'd1;
      event_next           = EV_CRC;
    end else if (parse.frame_ok) begin
      if (parse.frame_type == TYPE_STOP && parse.frame_length == 8'd0) begin
        mode_run_next      = 1'b0;
        active_flag_next   = 1'b0;
        linear_value_next  = '0;
        angular_value_next = '0;
        good_total_next    = good_total + 32'd1;
        event_next         = EV_GOOD;
      end else if (parse.frame_type == TYPE_RUN && parse.frame_length == 8'd0) begin
        mode_run_next      = 1'b1;
        active_flag_next   = 1'b0;
        linear_value_next  = '0;
        angular_value_next = '0;
        good_total_next    = good_total + 32'd1;
        event_next         = EV_GOOD;
      end else if (parse.frame_type == TYPE_DIFF && parse.frame_length == DIFF_LENGTH) begin
        if (is_nan_bits(diff_linear) || is_nan_bits(diff_angular)) begin
          type_error_total_next = type_error_total + 32'd1;
          event_next            = EV_TYPE;
        end else begin
          if (mode_run) begin
            linear_value_next  = diff_linear;
            angular_value_next = diff_angular;
            elapsed_ticks_next = '0;
            active_flag_next   = 1'b1;
          end
          good_total_next = good_total + 32'd1;
          event_next      = EV_GOOD;
        end
      end else begin
        type_error_total_next = type_error_total + 32'd1;
        event_next            = EV_TYPE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_run           <= 1'b0;
      active_flag        <= 1'b0;
      linear_value       <= '0;
      angular_value      <= '0;
      elapsed_ticks      <= '0;
      good_total         <= '0;
      crc_error_total    <= '0;
      length_error_total <= '0;
      type_error_total   <= '0;
    end else if (accept) begin
      mode_run           <= mode_run_next;
      active_flag        <= active_flag_next;
      linear_value       <= linear_value_next;
      angular_value      <= angular_value_next;
      elapsed_ticks      <= elapsed_ticks_next;
      good_total         <= good_total_next;
      crc_error_total    <= crc_error_total_next;
      length_error_total <= length_error_total_next;
      type_error_total   <= type_error_total_next;
    end
  end

  // Result register: load on every accepted beat, hold until read
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (accept) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result.frame_event        <= event_next;
      result.run_mode           <= mode_run_next;
      result.command_active     <= active_flag_next;
      result.linear_command     <= active_flag_next ? linear_value_next : 32'd0;
      result.angular_command    <= active_flag_next ? angular_value_next : 32'd0;
      result.good_count         <= good_total_next;
      result.crc_error_count    <= crc_error_total_next;
      result.length_error_count <= length_error_total_next;
      result.type_error_count   <= type_error_total_next;
    end
  end

  // An inactive command never carries stale values
  a_inactive_zero: assert property (@(posedge clk) disable iff (rst)
    !active_flag |-> (linear_value == 32'd0 && angular_value == 32'd0))
    else $error("inactive command holds nonzero values");

  // A live command only exists in run mode
  a_active_in_run: assert property (@(posedge clk) disable iff (rst)
    active_flag |-> mode_run)
    else $error("command active in stop mode");

  // Every accepted beat yields a result in the next cycle
  a_accept_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> result.valid)
    else $error("accepted beat produced no result");

  // A good frame advances the good counter by exactly one
  a_good_count: assert property (@(posedge clk) disable iff (rst)
    (accept && event_next == EV_GOOD) |=> good_total == $past(good_total) + 32'd1)
    else $error("good frame not counted");

  // State moves only on accepted beats
  a_hold_idle: assert property (@(posedge clk) disable iff (rst)
    !accept |=> ($stable(mode_run) && $stable(active_flag) && $stable(type_error_total)))
    else $error("state changed without an accepted beat");

endmodule

// ----- rtl/core/crc8cfp_frame_parser.sv -----
// Byte-level frame parser: header, type, length, payload, CRC-8/MAXIM.
// Depends on crc8cfp_pkg.

module crc8cfp_frame_parser
  import crc8cfp_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          byte_valid,
  input  logic [7:0]    rx_byte,
  input  logic [7:0]    header_value,
  output parse_result_t result
);

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_TYPE   = 3'd1,
    PH_LENGTH = 3'd2,
    PH_DATA   = 3'd3,
    PH_CRC    = 3'd4
  } phase_t;

  phase_t      phase, phase_next;
  logic [7:0]  frame_type, frame_type_next;
  logic [7:0]  frame_length, frame_length_next;
  logic [7:0]  payload_index, payload_index_next;
  logic [7:0]  running_crc, running_crc_next;
  logic [63:0] payload_bytes;
  logic [7:0]  crc_step;

  assign crc_step = crc8_next(running_crc, rx_byte);

  always_comb begin
    phase_next         = phase;
    frame_type_next    = frame_type;
    frame_length_next  = frame_length;
    payload_index_next = payload_index;
    running_crc_next   = running_crc;
    result              = '0;
    result.frame_type   = frame_type;
    result.frame_length = frame_length;
    result.payload      = payload_bytes;
    if (byte_valid) begin
      unique case (phase)
        PH_HEADER: begin
          if (rx_byte == header_value) begin
            running_crc_next = crc8_next(CRC_INIT, rx_byte);
            phase_next       = PH_TYPE;
          end
        end
        PH_TYPE: begin
          frame_type_next  = rx_byte;
          running_crc_next = crc_step;
          phase_next       = PH_LENGTH;
        end
        PH_LENGTH: begin
          frame_length_next = rx_byte;
          running_crc_next  = crc_step;
          if (rx_byte > MAX_LENGTH) begin
            result.length_error = 1'b1;
            phase_next          = PH_HEADER;
          end else begin
            payload_index_next = '0;
            phase_next         = (rx_byte == 8'd0) ? PH_CRC : PH_DATA;
          end
        end
        PH_DATA: begin
          payload_index_next = payload_index + 8'd1;
          running_crc_next   = crc_step;
          if (payload_index_next >= frame_length) begin
            phase_next = PH_CRC;
          end
        end
        PH_CRC: begin
          if (rx_byte == running_crc) begin
            result.frame_ok = 1'b1;
          end else begin
            result.crc_error = 1'b1;
          end
          phase_next = PH_HEADER;
        end
        default: begin
          phase_next = PH_HEADER;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEADER;
      frame_type    <= '0;
      frame_length  <= '0;
      payload_index <= '0;
      running_crc   <= '0;
    end else begin
      phase         <= phase_next;
      frame_type    <= frame_type_next;
      frame_length  <= frame_length_next;
      payload_index <= payload_index_next;
      running_crc   <= running_crc_next;
    end
  end

  // Keep only the first eight payload bytes, little-endian
  always_ff @(posedge clk) begin
    if (byte_valid && phase == PH_DATA && payload_index < STORED_BYTES) begin
      payload_bytes[{payload_index[2:0], 3'b000} +: 8] <= rx_byte;
    end
  end

endmodule

// ----- tb/sv/crc8_command_frame_parser_unit_test.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the CRC-8 command frame parser: serial bytes and ticks
// in, status beats out, checked against a frame/command predictor kept in step.
// Depends on crc8cfp_pkg, crc8cfp_if and the crc8_command_frame_parser_unit RTL.

module crc8_command_frame_parser_unit_test;
  import crc8cfp_pkg::*;

  typedef enum logic [2:0] {
    WAIT_HEADER,
    TAKE_TYPE,
    TAKE_LENGTH,
    TAKE_PAYLOAD,
    TAKE_CRC
  } parse_phase_t;

  typedef struct packed {
    logic       tick;
    logic [7:0] data;
  } serial_item_t;

  typedef struct packed {
    frame_event_t ev_code;
    logic         run;
    logic         live;
    logic [31:0]  lin;
    logic [31:0]  ang;
    logic [31:0]  n_good;
    logic [31:0]  n_crc;
    logic [31:0]  n_len;
    logic [31:0]  n_type;
  } status_beat_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  crc8cfp_item_if   item_ch ();
  crc8cfp_result_if result_ch ();

  crc8_command_frame_parser_unit i_dut (
    .clk     (clk),
    .rst     (rst),
    .item    (item_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Register copies and parser/command state of the predictor
  logic [15:0]  timeout_cfg;
  logic [7:0]   header_cfg;
  parse_phase_t phase_m;
  logic [7:0]   type_m;
  logic [7:0]   length_m;
  logic [7:0]   index_m;
  logic [7:0]   crc_m;
  logic [63:0]  payload_m;
  logic         mode_run_m;
  logic         active_m;
  logic [31:0]  lin_m;
  logic [31:0]  ang_m;
  logic [16:0]  age_m;
  logic [31:0]  good_m;
  logic [31:0]  crc_err_m;
  logic [31:0]  len_err_m;
  logic [31:0]  type_err_m;

  serial_item_t serial_items[$];
  status_beat_t status_expected[$];

  int unsigned bytes_queued;
  int unsigned items_accepted;
  int unsigned results_checked;
  int unsigned mismatches;
  int          tick_jitter;
  int          tick_burst_max;

  serial_item_t on_wire;
  bit           item_loaded;
  int           item_gap;
  bit           sender_steady;
  int           result_stall;
  bit           receiver_steady;

  function automatic logic [7:0] crc8_maxim_step(input logic [7:0] acc, input logic [7:0] d);
    logic [7:0] c;
    c = acc ^ d;
    repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    return c;
  endfunction

  function automatic logic float_is_nan(input logic [31:0] x);
    return (&x[30:23]) && (|x[22:0]);
  endfunction

  function automatic status_beat_t apply_serial_item(input serial_item_t it);
    frame_event_t ev;
    logic [31:0]  lo;
    logic [31:0]  hi;
    status_beat_t s;
    ev = EV_NONE;
    lo = payload_m[31:0];
    hi = payload_m[63:32];
    if (it.tick) begin
      if (active_m) begin
        if (age_m != AGE_MAX) age_m = age_m + 1'b1;
        if (age_m > {1'b0, timeout_cfg}) begin
          active_m = 1'b0;
          lin_m = '0;
          ang_m = '0;
        end
      end
    end else begin
      case (phase_m)
        WAIT_HEADER: begin
          if (it.data == header_cfg) begin
            crc_m = crc8_maxim_step(CRC_INIT, it.data);
            phase_m = TAKE_TYPE;
          end
        end
        TAKE_TYPE: begin
          type_m = it.data;
          crc_m = crc8_maxim_step(crc_m, it.data);
          phase_m = TAKE_LENGTH;
        end
        TAKE_LENGTH: begin
          length_m = it.data;
          crc_m = crc8_maxim_step(crc_m, it.data);
          if (it.data > MAX_LENGTH) begin
            len_err_m++;
            ev = EV_LENGTH;
            phase_m = WAIT_HEADER;
          end else begin
            index_m = '0;
            phase_m = (it.data == 8'd0) ? TAKE_CRC : TAKE_PAYLOAD;
          end
        end
        TAKE_PAYLOAD: begin
          // keep the first eight bytes only; the rest feed the CRC
          if (index_m < STORED_BYTES) payload_m[{index_m[2:0], 3'b000} +: 8] = it.data;
          index_m = index_m + 1'b1;
          crc_m = crc8_maxim_step(crc_m, it.data);
          if (index_m >= length_m) phase_m = TAKE_CRC;
        end
        TAKE_CRC: begin
          phase_m = WAIT_HEADER;
          if (it.data != crc_m) begin
            crc_err_m++;
            ev = EV_CRC;
          end else if ((type_m == TYPE_STOP || type_m == TYPE_RUN) && length_m == 8'd0) begin
            mode_run_m = (type_m == TYPE_RUN);
            active_m = 1'b0;
            lin_m = '0;
            ang_m = '0;
            good_m++;
            ev = EV_GOOD;
          end else if (type_m == TYPE_DIFF && length_m == DIFF_LENGTH &&
                       !float_is_nan(lo) && !float_is_nan(hi)) begin
            // stop mode counts the frame but leaves the command alone
            if (mode_run_m) begin
              lin_m = lo;
              ang_m = hi;
              age_m = '0;
              active_m = 1'b1;
            end
            good_m++;
            ev = EV_GOOD;
          end else begin
            type_err_m++;
            ev = EV_TYPE;
          end
        end
        default: phase_m = WAIT_HEADER;
      endcase
    end
    s.ev_code = ev;
    s.run     = mode_run_m;
    s.live    = active_m;
    s.lin     = active_m ? lin_m : 32'd0;
    s.ang     = active_m ? ang_m : 32'd0;
    s.n_good  = good_m;
    s.n_crc   = crc_err_m;
    s.n_len   = len_err_m;
    s.n_type  = type_err_m;
    return s;
  endfunction

  function automatic logic [31:0] plain_float();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 15))
      0: r[30:0] = '0;
      1: r[30:0] = {8'hFF, 23'd0};  // infinity, not NaN
      default: if (r[30:23] == 8'hFF) r[30] = 1'b0;
    endcase
    return r;
  endfunction

  task automatic push_byte(input logic [7:0] b);
    serial_items.push_back('{1'b0, b});
    bytes_queued++;
  endtask

  task automatic push_ticks(input int n);
    repeat (n) serial_items.push_back('{1'b1, 8'($urandom)});
  endtask

  // Build header, type, length, payload and CRC; cut_at > 0 truncates the frame.
  task automatic send_frame(input logic [7:0] typ, input logic [7:0] len,
                            input logic [63:0] lead, input bit spoil, input int cut_at);
    logic [7:0] bytes_out[$];
    logic [7:0] crc;
    bytes_out.push_back(header_cfg);
    bytes_out.push_back(typ);
    bytes_out.push_back(len);
    if (len <= MAX_LENGTH) begin
      for (int i = 0; i < len; i++) bytes_out.push_back(i < 8 ? lead[8*i +: 8] : 8'($urandom));
      crc = CRC_INIT;
      foreach (bytes_out[i]) crc = crc8_maxim_step(crc, bytes_out[i]);
      bytes_out.push_back(spoil ? crc ^ 8'($urandom_range(1, 255)) : crc);
    end
    if (cut_at > 0) begin
      while (bytes_out.size() > cut_at) void'(bytes_out.pop_back());
    end
    foreach (bytes_out[i]) begin
      if ($urandom_range(0, 99) < tick_jitter) push_ticks(1);
      push_byte(bytes_out[i]);
    end
  endtask

  task automatic send_random_frame();
    int unsigned sel;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] nan_bits;
    logic [7:0]  typ;
    bit          spoil;
    sel = $urandom_range(0, 99);
    a = plain_float();
    b = plain_float();
    nan_bits = {1'($urandom), 8'hFF, 23'($urandom_range(1, 23'h7FFFFF))};
    spoil = ($urandom_range(0, 9) == 0);
    case ($urandom_range(0, 2))
      0: typ = TYPE_STOP;
      1: typ = TYPE_RUN;
      default: typ = TYPE_DIFF;
    endcase
    if (sel < 40) begin
      send_frame(TYPE_DIFF, DIFF_LENGTH, {b, a}, spoil, 0);
    end else if (sel < 52) begin
      send_frame(TYPE_RUN, 8'd0, 64'($urandom), spoil, 0);
    end else if (sel < 59) begin
      send_frame(TYPE_STOP, 8'd0, 64'($urandom), spoil, 0);
    end else if (sel < 65) begin
      if ($urandom_range(0, 1) != 0) a = nan_bits;
      else b = nan_bits;
      send_frame(TYPE_DIFF, DIFF_LENGTH, {b, a}, spoil, 0);
    end else if (sel < 71) begin
      send_frame(8'($urandom), 8'($urandom_range(0, 8)), {b, a}, spoil, 0);
    end else if (sel < 76) begin
      // known type with a length that does not fit it
      send_frame(typ, 8'($urandom_range(1, 7)), {b, a}, spoil, 0);
    end else if (sel < 80) begin
      send_frame(8'($urandom), 8'($urandom_range(9, MAX_PAYLOAD)), {b, a}, spoil, 0);
    end else if (sel < 85) begin
      send_frame(8'($urandom), 8'($urandom_range(MAX_PAYLOAD + 1, 255)), '0, 1'b0, 0);
    end else if (sel < 92) begin
      repeat ($urandom_range(1, 4)) push_byte(8'($urandom));
    end else begin
      send_frame(TYPE_DIFF, DIFF_LENGTH, {b, a}, 1'b0, $urandom_range(1, 11));
    end
    if ($urandom_range(0, 2) == 0) push_ticks($urandom_range(0, tick_burst_max));
  endtask

  task automatic write_reg(input cfg_reg_t r, input logic [31:0] v);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (r == REG_TIMEOUT) timeout_cfg = v[15:0];
    else header_cfg = v[7:0];
  endtask

  // Hold the caller until every queued item is taken and every status beat seen.
  task automatic drain();
    do @(negedge clk);
    while (serial_items.size() != 0 || item_loaded || status_expected.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic run_phase(input logic [15:0] tmo, input logic [7:0] hdr,
                           input int burst, input int unsigned n_bytes);
    int unsigned stop_at;
    drain();
    write_reg(REG_TIMEOUT, {16'd0, tmo});
    write_reg(REG_HEADER, {24'd0, hdr});
    tick_burst_max = burst;
    tick_jitter = 8;
    stop_at = bytes_queued + n_bytes;
    while (bytes_queued < stop_at) send_random_frame();
  endtask

  // Sender: one gap draw per item, with stretches of back-to-back beats.
  always @(posedge clk) begin
    logic show;
    if (rst) begin
      item_ch.valid <= 1'b0;
      item_loaded = 1'b0;
      item_gap = 0;
    end else begin
      if (item_ch.valid && item_ch.ready) begin
        status_expected.push_back(apply_serial_item(on_wire));
        items_accepted++;
        item_loaded = 1'b0;
      end
      if (!item_loaded && serial_items.size() != 0) begin
        on_wire = serial_items.pop_front();
        item_loaded = 1'b1;
        if ($urandom_range(0, 39) == 0) sender_steady = !sender_steady;
        item_gap = sender_steady ? 0 : $urandom_range(0, 10);
      end
      show = item_loaded && item_gap == 0;
      if (item_loaded && item_gap != 0) item_gap--;
      item_ch.valid   <= show;
      item_ch.kind    <= on_wire.tick;
      item_ch.rx_byte <= on_wire.data;
    end
  end

  // Receiver: check each status beat, then hold ready low for a random stall.
  always @(posedge clk) begin
    status_beat_t seen;
    status_beat_t want;
    if (rst) begin
      result_ch.ready <= 1'b0;
      result_stall = 0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        seen.ev_code = frame_event_t'(result_ch.frame_event);
        seen.run     = result_ch.run_mode;
        seen.live    = result_ch.command_active;
        seen.lin     = result_ch.linear_command;
        seen.ang     = result_ch.angular_command;
        seen.n_good  = result_ch.good_count;
        seen.n_crc   = result_ch.crc_error_count;
        seen.n_len   = result_ch.length_error_count;
        seen.n_type  = result_ch.type_error_count;
        results_checked++;
        if (status_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("%0t: status beat with nothing predicted", $realtime);
        end else begin
          want = status_expected.pop_front();
          if (seen !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: want ev=%0d run=%b act=%b lin=%h ang=%h cnt=%0d/%0d/%0d/%0d",
                       $realtime, want.ev_code, want.run, want.live, want.lin, want.ang,
                       want.n_good, want.n_crc, want.n_len, want.n_type);
              $display("%0t: got  ev=%0d run=%b act=%b lin=%h ang=%h cnt=%0d/%0d/%0d/%0d",
                       $realtime, seen.ev_code, seen.run, seen.live, seen.lin, seen.ang,
                       seen.n_good, seen.n_crc, seen.n_len, seen.n_type);
            end
          end
        end
        if ($urandom_range(0, 39) == 0) receiver_steady = !receiver_steady;
        result_stall = receiver_steady ? 0 : $urandom_range(0, 10);
      end
      if (result_stall != 0) begin
        result_stall--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    item_ch.valid = 1'b0;
    item_ch.kind = 1'b0;
    item_ch.rx_byte = '0;
    result_ch.ready = 1'b0;
    on_wire = '0;
    sender_steady = 1'b0;
    receiver_steady = 1'b0;
    bytes_queued = 0;
    items_accepted = 0;
    results_checked = 0;
    mismatches = 0;
    tick_jitter = 0;
    tick_burst_max = 0;
    timeout_cfg = TIMEOUT_RESET;
    header_cfg = HEADER_RESET;
    phase_m = WAIT_HEADER;
    type_m = '0;
    length_m = '0;
    index_m = '0;
    crc_m = '0;
    payload_m = '0;
    mode_run_m = 1'b0;
    active_m = 1'b0;
    lin_m = '0;
    ang_m = '0;
    age_m = '0;
    good_m = '0;
    crc_err_m = '0;
    len_err_m = '0;
    type_err_m = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed frames at reset register values
    push_ticks(1);
    send_frame(TYPE_RUN, 8'd0, '0, 1'b0, 0);
    // header byte inside the payload, most negative finite angular value
    tick_jitter = 30;
    send_frame(TYPE_DIFF, DIFF_LENGTH, {32'hFF7F_FFFF, 32'h0000_00A5}, 1'b0, 0);
    tick_jitter = 0;
    send_frame(TYPE_DIFF, MAX_LENGTH + 8'd1, '0, 1'b0, 0);
    send_frame(8'hFF, 8'd0, '0, 1'b0, 0);
    send_frame(TYPE_STOP, 8'd0, '0, 1'b1, 0);
    push_ticks(2);
    send_frame(TYPE_STOP, 8'd0, '0, 1'b0, 0);

    run_phase(16'd500, 8'hA5, 4, 65);
    run_phase(16'd0, 8'h00, 3, 65);
    run_phase(16'd6, 8'hFF, 12, 65);
    run_phase(16'hFFFF, 8'h5A, 8, 65);
    run_phase(16'd2, 8'hA5, 5, 65);
    drain();
    repeat (4) @(posedge clk);

    $display("Checked %0d status beats for %0d bytes and ticks over six register settings.",
             results_checked, items_accepted);
    $display("Frames seen: %0d good, %0d CRC, %0d length, %0d type errors; %0d mismatches.",
             good_m, crc_err_m, len_err_m, type_err_m, mismatches);
    if (mismatches == 0 && status_expected.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Run timed out with %0d status beats outstanding.", status_expected.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
